// ===== rtl/core/rct_pkg.sv =====
// shared types and constants for the reference count table
package rct_pkg;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int ADDR_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_ASSIGN  = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_DONE    = 2'd0,
      KIND_FREED   = 2'd1,
      KIND_FULL    = 2'd2,
      KIND_NOTHING = 2'd3
   } kind_type;

   // request token that walks down the row of cells
   typedef struct packed {
      req_code_type         op;
      logic                 same;
      logic [ADDR_BITS-1:0] old_address;
      logic [ADDR_BITS-1:0] new_address;
      logic                 placed;
      logic                 old_hit;
      logic                 new_hit;
      logic                 held_valid;
      logic [ADDR_BITS-1:0] held_address;
   } tok_type;

   // early result pushed by a cell during release all
   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] address;
   } emit_type;

endpackage

// ===== rtl/core/rct_req_if.sv =====
// request channel interface
interface rct_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [rct_pkg::ADDR_BITS-1:0] old_address;
   logic [rct_pkg::ADDR_BITS-1:0] new_address;

   modport source (output valid, output req_type, output old_address,
                   output new_address, input ready);
   modport sink   (input valid, input req_type, input old_address,
                   input new_address, output ready);
endinterface

// ===== rtl/core/rct_rsp_if.sv =====
// response channel interface
interface rct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    result_kind;
   logic [rct_pkg::ADDR_BITS-1:0] freed_address;
   logic                          last;

   modport source (output valid, output result_kind, output freed_address,
                   output last, input ready);
   modport sink   (input valid, input result_kind, input freed_address,
                   input last, output ready);
endinterface

// ===== rtl/core/rct_cell.sv =====
// one table slot: live bit, address and count, acting on the passing token
module rct_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             prev_valid,
   input  rct_pkg::tok_type prev_tok,
   input  logic             emit_ready,
   output logic             next_valid,
   output rct_pkg::tok_type next_tok,
   output rct_pkg::emit_type emit
);

   logic                              tok_vld_ff, tok_vld_in;
   rct_pkg::tok_type                  tok_ff, tok_in;
   logic                              live_ff, live_in;
   logic [rct_pkg::ADDR_BITS-1:0]     address_ff, address_in;
   logic [rct_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   rct_pkg::tok_type                  tok_out;
   logic                              need_emit;
   logic                              stall;

   // release all pushes the previously held address when it meets another live slot
   assign need_emit = tok_vld_ff && (tok_ff.op == rct_pkg::REQ_RELEASE) &&
                      live_ff && tok_ff.held_valid;
   assign stall     = need_emit && !emit_ready;

   // slot update and token update
   always_comb begin
      tok_out    = tok_ff;
      live_in    = live_ff;
      address_in = address_ff;
      count_in   = count_ff;
      if (tok_vld_ff && !stall) begin
         unique case (tok_ff.op)
            rct_pkg::REQ_ALLOC: begin
               if (!tok_ff.placed && !live_ff) begin
                  live_in        = 1'b1;
                  address_in     = tok_ff.new_address;
                  count_in       = rct_pkg::COUNT_ONE;
                  tok_out.placed = 1'b1;
               end
            end
            rct_pkg::REQ_ASSIGN: begin
               if (!tok_ff.same && live_ff) begin
                  if (!tok_ff.old_hit && address_ff == tok_ff.old_address) begin
                     tok_out.old_hit = 1'b1;
                     if (count_ff <= rct_pkg::COUNT_ONE) begin
                        live_in              = 1'b0;
                        count_in             = '0;
                        tok_out.held_valid   = 1'b1;
                        tok_out.held_address = address_ff;
                     end else begin
                        count_in = count_ff - rct_pkg::COUNT_ONE;
                     end
                  end else if (!tok_ff.new_hit && address_ff == tok_ff.new_address) begin
                     tok_out.new_hit = 1'b1;
                     if (count_ff != rct_pkg::COUNT_MAX) begin
                        count_in = count_ff + rct_pkg::COUNT_ONE;
                     end
                  end
               end
            end
            rct_pkg::REQ_RELEASE: begin
               if (live_ff) begin
                  live_in              = 1'b0;
                  tok_out.held_valid   = 1'b1;
                  tok_out.held_address = address_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // token moves on unless waiting for the output register
   always_comb begin
      if (stall) begin
         tok_vld_in = tok_vld_ff;
         tok_in     = tok_ff;
      end else begin
         tok_vld_in = prev_valid;
         tok_in     = prev_tok;
      end
   end

   assign next_valid   = tok_vld_ff && !stall;
   assign next_tok     = tok_out;
   assign emit.valid   = need_emit && emit_ready;
   assign emit.address = tok_ff.held_address;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff <= 1'b0;
         live_ff    <= 1'b0;
      end else begin
         tok_vld_ff <= tok_vld_in;
         live_ff    <= live_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tok_ff     <= tok_in;
      address_ff <= address_in;
      count_ff   <= count_in;
   end

endmodule

// ===== rtl/core/reference_count_table.sv =====
// reference count table: top level with the row of slot cells and the output register
//
//  channel   | dir | transfer when         | payload
//  req_chan  | in  | valid && ready        | req_type, old_address, new_address
//  rsp_chan  | out | valid && ready        | result_kind, freed_address, last
//
// a request token walks the row of ENTRIES cells, one cell per cycle while no cell
// waits for the output register, then reaches a tail register, from which its final
// response is loaded into the output register; the next request can transfer in the
// cycle after that final response is loaded. a release-all output or the final
// response that finds the output register full waits until it can be loaded.
// one request is in the row at a time.
// synchronous active-high reset empties the table and drops any request in flight.
module reference_count_table (
   input logic        clock,
   input logic        reset,
   rct_req_if.sink    req_chan,
   rct_rsp_if.source  rsp_chan
);

   logic                          busy_ff, busy_in;
   logic                          tail_vld_ff, tail_vld_in;
   rct_pkg::tok_type              tail_tok_ff;
   logic                          rsp_vld_ff, rsp_vld_in;
   rct_pkg::kind_type             rsp_kind_ff, rsp_kind_in;
   logic [rct_pkg::ADDR_BITS-1:0] rsp_address_ff, rsp_address_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_xfer;
   logic                          emit_ready;
   logic                          load_final;
   logic                          emit_any;
   logic [rct_pkg::ADDR_BITS-1:0] emit_address;
   rct_pkg::kind_type             final_kind;
   logic [rct_pkg::ADDR_BITS-1:0] final_address;
   rct_pkg::tok_type              head_tok;

   logic                          valid_chain [rct_pkg::ENTRIES+1];
   rct_pkg::tok_type              tok_chain   [rct_pkg::ENTRIES+1];
   rct_pkg::emit_type             emit_arr    [rct_pkg::ENTRIES];

   assign req_chan.ready = !busy_ff;
   assign req_xfer       = req_chan.valid && !busy_ff;
   assign emit_ready     = !rsp_vld_ff || rsp_chan.ready;
   assign load_final     = tail_vld_ff && emit_ready;

   // fresh token for an accepted request
   always_comb begin
      head_tok              = '0;
      head_tok.op           = rct_pkg::req_code_type'(req_chan.req_type);
      head_tok.same         = (req_chan.old_address == req_chan.new_address);
      head_tok.old_address  = req_chan.old_address;
      head_tok.new_address  = req_chan.new_address;
   end

   assign valid_chain[0] = req_xfer;
   assign tok_chain[0]   = head_tok;

   // row of slot cells
   for (genvar i = 0; i < rct_pkg::ENTRIES; i++) begin : g_cell
      rct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (valid_chain[i]),
         .prev_tok   (tok_chain[i]),
         .emit_ready (emit_ready),
         .next_valid (valid_chain[i+1]),
         .next_tok   (tok_chain[i+1]),
         .emit       (emit_arr[i])
      );
   end

   // at most one cell pushes an output in a cycle
   always_comb begin
      emit_any     = 1'b0;
      emit_address = '0;
      for (int i = 0; i < rct_pkg::ENTRIES; i++) begin
         emit_any     = emit_any | emit_arr[i].valid;
         emit_address = emit_address |
                        (emit_arr[i].valid ? emit_arr[i].address : '0);
      end
   end

   // final response from the token leaving the row
   always_comb begin
      final_kind    = rct_pkg::KIND_DONE;
      final_address = '0;
      unique case (tail_tok_ff.op)
         rct_pkg::REQ_ALLOC: begin
            final_kind = tail_tok_ff.placed ? rct_pkg::KIND_DONE : rct_pkg::KIND_FULL;
         end
         rct_pkg::REQ_ASSIGN: begin
            if (tail_tok_ff.held_valid) begin
               final_kind    = rct_pkg::KIND_FREED;
               final_address = tail_tok_ff.held_address;
            end
         end
         rct_pkg::REQ_RELEASE: begin
            if (tail_tok_ff.held_valid) begin
               final_kind    = rct_pkg::KIND_FREED;
               final_address = tail_tok_ff.held_address;
            end else begin
               final_kind = rct_pkg::KIND_NOTHING;
            end
         end
         default: begin
            final_kind = rct_pkg::KIND_DONE;
         end
      endcase
   end

   // request busy flag and tail stage
   always_comb begin
      busy_in     = busy_ff;
      tail_vld_in = tail_vld_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end
      if (valid_chain[rct_pkg::ENTRIES]) begin
         tail_vld_in = 1'b1;
      end else if (load_final) begin
         tail_vld_in = 1'b0;
         busy_in     = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_vld_in     = rsp_vld_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_address_in = rsp_address_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit_any) begin
         rsp_vld_in     = 1'b1;
         rsp_kind_in    = rct_pkg::KIND_FREED;
         rsp_address_in = emit_address;
         rsp_last_in    = 1'b0;
      end else if (load_final) begin
         rsp_vld_in     = 1'b1;
         rsp_kind_in    = final_kind;
         rsp_address_in = final_address;
         rsp_last_in    = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         tail_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         tail_vld_ff <= tail_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (valid_chain[rct_pkg::ENTRIES]) begin
         tail_tok_ff <= tok_chain[rct_pkg::ENTRIES];
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_address_ff <= rsp_address_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.result_kind   = rsp_kind_ff;
   assign rsp_chan.freed_address = rsp_address_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule
